/* rtl/lcas_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcas_pkg
// Shared types, codes and the birth/survival rule for the life step block.
// ----------------------------------------------------------------------------
package lcas_pkg;

    localparam logic OP_CELL  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam int CFG_DATA_W  = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int COLUMN_W    = 7;
    localparam int ROW_W       = 6;

    typedef struct packed {
        logic opcode;
        logic alive;
    } cell_in_t;

    typedef struct packed {
        logic                next_alive;
        logic [COLUMN_W-1:0] cell_column;
        logic [ROW_W-1:0]    cell_row;
        logic                last_of_frame;
    } result_t;

    // One column position of the two line buffers.
    typedef struct packed {
        logic mid;
        logic top;
    } line_t;

    // B3/S23 on a 3x3 window; bit 4 is the center cell.
    function automatic logic rule_of(input logic [8:0] win);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 9; i++)
        begin
            if (i != 4)
            begin
                n = n + 4'(win[i]);
            end
        end
        return (n == 4'd3) || ((n == 4'd2) && win[4]);
    endfunction

endpackage
`default_nettype wire

/* rtl/lcas_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcas_cell
// One column slot of the two line buffers. Each slot passes its contents
// toward slot zero on every shift and loads fresh data when it is the far
// end of the active row width.
// ----------------------------------------------------------------------------
module lcas_cell #(
    parameter int WIDTH_W = 8,
    parameter int INDEX   = 0
) (
    input  wire logic                 clk,
    input  wire logic                 shift_en,
    input  wire logic [WIDTH_W-1:0]   width_eff,
    input  wire lcas_pkg::line_t      inject,
    input  wire lcas_pkg::line_t      neighbor,
    output      lcas_pkg::line_t      value
);

    lcas_pkg::line_t data_reg;
    lcas_pkg::line_t data_next;
    logic            is_end;

    assign is_end = (width_eff == WIDTH_W'(INDEX + 1));

    always_comb
    begin
        data_next = data_reg;
        if (shift_en)
        begin
            data_next = is_end ? inject : neighbor;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign value = data_reg;

endmodule
`default_nettype wire

/* rtl/lcas_window.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcas_window
// The 3x3 neighbor window, held column by column, and the rule evaluation
// for the cell at its center.
// ----------------------------------------------------------------------------
module lcas_window (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       shift_en,
    input  wire logic       col_zero,
    input  wire logic [2:0] new_col,
    output      logic       next_alive
);

    logic [8:0] win_reg;
    logic [8:0] win_next;
    logic [8:0] win_shifted;

    assign win_shifted = {new_col, win_reg[8:3]};

    always_comb
    begin
        win_next = win_reg;
        if (shift_en)
        begin
            win_next = col_zero ? {new_col, 6'b0} : win_shifted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    // At the start of a row the window closes out the previous row's last cell.
    assign next_alive = col_zero ? lcas_pkg::rule_of({3'b0, win_reg[8:3]})
                                 : lcas_pkg::rule_of(win_shifted);

endmodule
`default_nettype wire

/* rtl/life_cellular_automaton_step_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// life_cellular_automaton_step_top
// One Game of Life generation (B3/S23) over a raster-streamed bounded grid.
// ----------------------------------------------------------------------------
// The block takes one cell per clock and delivers one result per clock. A
// result is registered at the transfer that completes its neighborhood and is
// offered in the next cycle; the input stalls only while a result waits on a
// stalled output. A cell's result follows width+1 cell or flush transfers
// after the cell itself, set by the two line buffers, which are a chain of
// MAX_WIDTH column slots shifting once per cell or flush transfer, and the
// 3x3 window. After the last cell of a frame, width+1 drain transfers flush
// the rest; the final result of a frame carries last_of_frame. Drains outside
// a frame produce nothing and shift nothing, and a cell sent during the flush
// counts as a drain. Width and height are clamped to 3..MAX_WIDTH and
// 3..MAX_HEIGHT; a register write restarts the frame.
// ----------------------------------------------------------------------------
module life_cellular_automaton_step_top #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cell_valid,
    output      logic                               cell_stall,
    input  wire lcas_pkg::cell_in_t                 cell_data,
    output      logic                               result_valid,
    input  wire logic                               result_stall,
    output      lcas_pkg::result_t                  result_data,
    input  wire logic                               cfg_write_en,
    input  wire logic [lcas_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [lcas_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CLW   = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT + 2);
    localparam int WCMP  = (WW > 8) ? WW : 8;
    localparam int HCMP  = (HW > 7) ? HW : 7;
    localparam int CXW   = (WW > lcas_pkg::COLUMN_W) ? WW : lcas_pkg::COLUMN_W;
    localparam int RXW   = (RW > lcas_pkg::ROW_W) ? RW : lcas_pkg::ROW_W;

    logic [7:0]         width_reg;
    logic [7:0]         width_next;
    logic [6:0]         height_reg;
    logic [6:0]         height_next;
    logic [CLW-1:0]     col_reg;
    logic [CLW-1:0]     col_next;
    logic [RW-1:0]      row_reg;
    logic [RW-1:0]      row_next;
    logic               rvalid_reg;
    logic               rvalid_next;
    lcas_pkg::result_t  rdata_reg;
    lcas_pkg::result_t  rdata_next;

    logic [WCMP-1:0]    width_ext;
    logic [HCMP-1:0]    height_ext;
    logic [WW-1:0]      w_eff;
    logic [HW-1:0]      h_eff;
    logic [RW-1:0]      h_row;
    logic               accept;
    logic               step;
    logic               draining;
    logic               row_end;
    logic               col_zero;
    logic               col_last;
    logic               have;
    logic               bot;
    logic [2:0]         new_col;
    logic               rule_out;
    lcas_pkg::line_t    tap;
    lcas_pkg::line_t    inject;
    lcas_pkg::line_t    chain [0:MAX_WIDTH];

    // Clamp the configured sizes.
    always_comb
    begin
        width_ext  = WCMP'(width_reg);
        height_ext = HCMP'(height_reg);
        if (width_ext < WCMP'(3))
        begin
            w_eff = WW'(3);
        end
        else if (width_ext > WCMP'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_ext);
        end
        if (height_ext < HCMP'(3))
        begin
            h_eff = HW'(3);
        end
        else if (height_ext > HCMP'(MAX_HEIGHT))
        begin
            h_eff = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HW'(height_ext);
        end
    end

    assign h_row    = RW'(h_eff);
    assign accept   = cell_valid && !cell_stall;
    assign draining = (row_reg >= h_row);
    assign row_end  = (row_reg == h_row + RW'(1));
    assign step     = accept && (draining || (cell_data.opcode == lcas_pkg::OP_CELL));
    assign col_zero = (col_reg == '0);
    assign col_last = (WW'(col_reg) == w_eff - WW'(1));
    assign bot      = draining ? 1'b0 : cell_data.alive;

    // Line buffer chain; slot zero holds the oldest column.
    assign tap              = chain[0];
    assign inject.mid       = bot;
    assign inject.top       = tap.mid;
    assign chain[MAX_WIDTH] = '0;

    for (genvar i = 0; i < MAX_WIDTH; i++)
    begin : g_slot
        lcas_cell #(
            .WIDTH_W (WW),
            .INDEX   (i)
        ) u_cell (
            .clk       (clk),
            .shift_en  (step),
            .width_eff (w_eff),
            .inject    (inject),
            .neighbor  (chain[i + 1]),
            .value     (chain[i])
        );
    end

    // Rows above the grid read as dead.
    assign new_col = {bot,
                      tap.mid && (row_reg >= RW'(1)),
                      tap.top && (row_reg >= RW'(2))};

    lcas_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift_en   (step),
        .col_zero   (col_zero),
        .new_col    (new_col),
        .next_alive (rule_out)
    );

    assign have = col_zero ? (row_reg >= RW'(2)) : (row_reg >= RW'(1));

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                lcas_pkg::REG_WIDTH:  width_next  = cfg_data;
                lcas_pkg::REG_HEIGHT: height_next = cfg_data[6:0];
                default:              width_next  = width_reg;
            endcase
            col_next = '0;
            row_next = '0;
        end
        else if (step)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_last)
            begin
                col_next = '0;
                row_next = row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CLW'(1);
            end
        end
    end

    always_comb
    begin
        rdata_next = rdata_reg;
        if (col_zero)
        begin
            rdata_next.cell_column = lcas_pkg::COLUMN_W'(CXW'(w_eff) - CXW'(1));
            rdata_next.cell_row    = lcas_pkg::ROW_W'(RXW'(row_reg) - RXW'(2));
        end
        else
        begin
            rdata_next.cell_column = lcas_pkg::COLUMN_W'(CXW'(col_reg) - CXW'(1));
            rdata_next.cell_row    = lcas_pkg::ROW_W'(RXW'(row_reg) - RXW'(1));
        end
        rdata_next.next_alive    = rule_out;
        rdata_next.last_of_frame = col_zero && row_end;

        if (step && have)
        begin
            rvalid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            rvalid_next = 1'b0;
        end
        else
        begin
            rvalid_next = rvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 8'd120;
            height_reg <= 7'd40;
            col_reg    <= '0;
            row_reg    <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && have)
        begin
            rdata_reg <= rdata_next;
        end
    end

    assign cell_stall   = rvalid_reg && result_stall;
    assign result_valid = rvalid_reg;
    assign result_data  = rdata_reg;

endmodule
`default_nettype wire

/* verif/tb_life_cellular_automaton_step_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_life_cellular_automaton_step_top
// Self-checking testbench for one Game of Life generation over a streamed
// grid. A queue of cells and drain steps feeds a clocked driver with random
// gaps, and a clocked monitor with random stalls checks every result against
// a cycle-free predictor of the line buffers and the 3x3 window. The run
// covers directed corner cases and clamped register values, then random
// frames at many grid sizes, including cut-short frames and noise drains.
// ----------------------------------------------------------------------------
module tb_life_cellular_automaton_step_top;

    localparam int GRID_MAX_W    = 128;
    localparam int GRID_MAX_H    = 64;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int ITEM_TARGET   = 1700;
    localparam int SETTLE_CYCLES = 6;
    localparam int REPORT_MAX    = 10;

    logic                                   clk          = 1'b0;
    logic                                   rst_n        = 1'b0;
    logic                                   cell_valid   = 1'b0;
    logic                                   cell_stall;
    lcas_pkg::cell_in_t                     cell_data    = '0;
    logic                                   result_valid;
    logic                                   result_stall = 1'b0;
    lcas_pkg::result_t                      result_data;
    logic                                   cfg_write_en = 1'b0;
    logic [lcas_pkg::CFG_INDEX_W-1:0]       cfg_index    = '0;
    logic [lcas_pkg::CFG_DATA_W-1:0]        cfg_data     = '0;

    life_cellular_automaton_step_top #(
        .MAX_WIDTH  (GRID_MAX_W),
        .MAX_HEIGHT (GRID_MAX_H)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cell_valid   (cell_valid),
        .cell_stall   (cell_stall),
        .cell_data    (cell_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Predictor state: line buffers, window, raster position and flush count.
    bit                   line_mem [0:2*GRID_MAX_W-1];
    logic [8:0]           nbr_win    = '0;
    int unsigned          in_col     = 0;
    int unsigned          in_row     = 0;
    int unsigned          flush_left = 0;
    logic [7:0]           width_reg  = 8'd120;
    logic [6:0]           height_reg = 7'd40;

    lcas_pkg::cell_in_t   cell_q[$];
    lcas_pkg::result_t    next_gen_q[$];

    int unsigned          sent_items  = 0;
    int unsigned          fail_count  = 0;
    int unsigned          cycle_count = 0;
    int unsigned          send_gap    = 0;
    int unsigned          hold_left   = 0;
    int unsigned          rx_draw     = 0;
    bit                   send_busy   = 1'b0;
    bit                   recv_busy   = 1'b0;

    function int unsigned grid_w();
        if (width_reg < 8'd3)
        begin
            return 3;
        end
        if (width_reg > GRID_MAX_W)
        begin
            return GRID_MAX_W;
        end
        return 32'(width_reg);
    endfunction

    function int unsigned grid_h();
        if (height_reg < 7'd3)
        begin
            return 3;
        end
        if (height_reg > GRID_MAX_H)
        begin
            return GRID_MAX_H;
        end
        return 32'(height_reg);
    endfunction

    function bit b3s23(logic [8:0] win);
        int unsigned n;
        n = $countones(win) - int'(win[4]);
        return (n == 3) || ((n == 2) && win[4]);
    endfunction

    function void shift_window(int unsigned ri, int unsigned ci, bit bot, bit store,
                               int unsigned w, int unsigned h);
        int unsigned       col;
        int unsigned       top_i;
        int unsigned       mid_i;
        int unsigned       ro;
        int unsigned       co;
        bit                top;
        bit                mid;
        bit                have;
        logic [2:0]        newcol;
        lcas_pkg::result_t r;
        col   = ci % GRID_MAX_W;
        top_i = (ri % 2) * GRID_MAX_W + col;
        mid_i = ((ri + 1) % 2) * GRID_MAX_W + col;
        top   = (ri >= 2) ? line_mem[top_i] : 1'b0;
        mid   = (ri >= 1) ? line_mem[mid_i] : 1'b0;
        newcol = {bot, mid, top};
        have = 1'b0;
        ro = 0;
        co = 0;
        r = '0;
        if (store)
        begin
            line_mem[top_i] = bot;
        end
        if (ci == 0)
        begin
            if (ri >= 2)
            begin
                r.next_alive = b3s23({3'b000, nbr_win[8:3]});
                ro = ri - 2;
                co = w - 1;
                have = 1'b1;
            end
            nbr_win = {newcol, 6'b000000};
        end
        else
        begin
            nbr_win = {newcol, nbr_win[8:3]};
            if (ri >= 1 && ri <= h)
            begin
                r.next_alive = b3s23(nbr_win);
                ro = ri - 1;
                co = ci - 1;
                have = 1'b1;
            end
        end
        if (have)
        begin
            r.cell_column   = lcas_pkg::COLUMN_W'(co);
            r.cell_row      = lcas_pkg::ROW_W'(ro);
            r.last_of_frame = (ro == h - 1) && (co == w - 1);
            next_gen_q.push_back(r);
        end
    endfunction

    function void life_step(lcas_pkg::cell_in_t item);
        int unsigned w;
        int unsigned h;
        int unsigned d;
        w = grid_w();
        h = grid_h();
        if (flush_left != 0)
        begin
            d = w + 1 - flush_left;
            flush_left--;
            if (d < w)
            begin
                shift_window(h, d, 1'b0, 1'b0, w, h);
            end
            else
            begin
                shift_window(h + 1, 0, 1'b0, 1'b0, w, h);
            end
        end
        else if (item.opcode == lcas_pkg::OP_CELL)
        begin
            shift_window(in_row, in_col, item.alive, 1'b1, w, h);
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
                if (in_row >= h)
                begin
                    in_row = 0;
                    flush_left = w + 1;
                end
            end
        end
    endfunction

    function void write_reg(logic [lcas_pkg::CFG_INDEX_W-1:0] idx,
                            logic [lcas_pkg::CFG_DATA_W-1:0] val);
        if (idx == lcas_pkg::REG_WIDTH)
        begin
            width_reg = val;
        end
        else
        begin
            height_reg = val[6:0];
        end
        in_col = 0;
        in_row = 0;
        flush_left = 0;
    endfunction

    function int unsigned draw_wait(bit busy);
        return busy ? $urandom_range(0, 7) : 0;
    endfunction

    function void check_result(lcas_pkg::result_t got);
        lcas_pkg::result_t want;
        if (next_gen_q.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
            begin
                $display("unexpected result: alive=%0d col=%0d row=%0d last=%0d",
                         got.next_alive, got.cell_column, got.cell_row,
                         got.last_of_frame);
            end
        end
        else
        begin
            want = next_gen_q.pop_front();
            if (got.next_alive !== want.next_alive ||
                got.cell_column !== want.cell_column ||
                got.cell_row !== want.cell_row ||
                got.last_of_frame !== want.last_of_frame)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                begin
                    $display({"mismatch: expected alive=%0d col=%0d row=%0d last=%0d,",
                              " got alive=%0d col=%0d row=%0d last=%0d"},
                             want.next_alive, want.cell_column, want.cell_row,
                             want.last_of_frame, got.next_alive, got.cell_column,
                             got.cell_row, got.last_of_frame);
                end
            end
        end
    endfunction

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_valid <= 1'b0;
            cell_data  <= '0;
            send_gap   <= 0;
        end
        else
        begin
            if (cell_valid && !cell_stall)
            begin
                life_step(cell_data);
                if ($urandom_range(0, 39) == 0)
                begin
                    send_busy = !send_busy;
                end
            end
            if (!cell_valid || !cell_stall)
            begin
                if (send_gap != 0)
                begin
                    cell_valid <= 1'b0;
                    send_gap   <= send_gap - 1;
                end
                else if (cell_q.size() != 0)
                begin
                    cell_data  <= cell_q.pop_front();
                    cell_valid <= 1'b1;
                    send_gap   <= draw_wait(send_busy);
                end
                else
                begin
                    cell_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left    <= 0;
        end
        else if (result_valid && !result_stall)
        begin
            check_result(result_data);
            if ($urandom_range(0, 39) == 0)
            begin
                recv_busy = !recv_busy;
            end
            rx_draw = draw_wait(recv_busy);
            result_stall <= (rx_draw != 0);
            hold_left    <= rx_draw;
        end
        else if (result_stall)
        begin
            if (hold_left <= 1)
            begin
                result_stall <= 1'b0;
                hold_left    <= 0;
            end
            else
            begin
                hold_left <= hold_left - 1;
            end
        end
    end

    task push_item(logic op, logic alive);
        lcas_pkg::cell_in_t it;
        it.opcode = op;
        it.alive  = alive;
        cell_q.push_back(it);
    endtask

    task wait_idle();
        @(negedge clk);
        while (cell_q.size() != 0 || cell_valid || next_gen_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_cfg(logic [lcas_pkg::CFG_DATA_W-1:0] w_val,
                   logic [lcas_pkg::CFG_DATA_W-1:0] h_val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= lcas_pkg::REG_WIDTH;
        cfg_data     <= w_val;
        write_reg(lcas_pkg::REG_WIDTH, w_val);
        @(posedge clk);
        cfg_index    <= lcas_pkg::REG_HEIGHT;
        cfg_data     <= h_val;
        write_reg(lcas_pkg::REG_HEIGHT, h_val);
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(negedge clk);
    endtask

    task add_frame(int unsigned cells);
        int unsigned w;
        int unsigned h;
        int unsigned density;
        int unsigned noise;
        w = grid_w();
        h = grid_h();
        density = $urandom_range(0, 100);
        noise = $urandom_range(0, 10);
        for (int unsigned k = 0; k < cells; k++)
        begin
            if ($urandom_range(0, 99) < noise)
            begin
                push_item(lcas_pkg::OP_DRAIN, 1'($urandom_range(0, 1)));
            end
            push_item(lcas_pkg::OP_CELL, $urandom_range(0, 99) < density);
            sent_items++;
        end
        if (cells == w * h)
        begin
            for (int unsigned k = 0; k <= w; k++)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    push_item(lcas_pkg::OP_CELL, 1'($urandom_range(0, 1)));
                end
                else
                begin
                    push_item(lcas_pkg::OP_DRAIN, 1'($urandom_range(0, 1)));
                end
                sent_items++;
            end
            if ($urandom_range(0, 1) == 1)
            begin
                push_item(lcas_pkg::OP_DRAIN, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task random_phase();
        logic [lcas_pkg::CFG_DATA_W-1:0] wv;
        logic [lcas_pkg::CFG_DATA_W-1:0] hv;
        int unsigned                     total;
        int unsigned                     frames;
        int unsigned                     cells;
        case ($urandom_range(0, 19))
            0:       wv = lcas_pkg::CFG_DATA_W'($urandom_range(0, 2));
            1:       wv = lcas_pkg::CFG_DATA_W'($urandom_range(129, 255));
            2, 3:    wv = lcas_pkg::CFG_DATA_W'($urandom_range(13, 128));
            default: wv = lcas_pkg::CFG_DATA_W'($urandom_range(3, 12));
        endcase
        case ($urandom_range(0, 19))
            0:       hv = lcas_pkg::CFG_DATA_W'($urandom_range(0, 2));
            1:       hv = lcas_pkg::CFG_DATA_W'($urandom_range(65, 255));
            2, 3:    hv = lcas_pkg::CFG_DATA_W'($urandom_range(9, 64));
            default: hv = lcas_pkg::CFG_DATA_W'($urandom_range(3, 8));
        endcase
        wait_idle();
        write_cfg(wv, hv);
        total = grid_w() * grid_h();
        frames = $urandom_range(1, 3);
        for (int unsigned f = 0; f < frames; f++)
        begin
            if (total > 600)
            begin
                cells = $urandom_range(1, 600);
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                cells = $urandom_range(1, total - 1);
            end
            else
            begin
                cells = total;
            end
            add_frame(cells);
            if (cells < total)
            begin
                break;
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // A horizontal blinker on the smallest grid, with drains before and
        // after the frame and a cell sent during the flush.
        write_cfg(8'd3, 8'd3);
        push_item(lcas_pkg::OP_DRAIN, 1'b1);
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                push_item(lcas_pkg::OP_CELL, r == 1);
                sent_items++;
            end
        end
        push_item(lcas_pkg::OP_DRAIN, 1'b0);
        push_item(lcas_pkg::OP_DRAIN, 1'b1);
        push_item(lcas_pkg::OP_CELL, 1'b1);
        push_item(lcas_pkg::OP_DRAIN, 1'b0);
        push_item(lcas_pkg::OP_DRAIN, 1'b0);
        sent_items += 4;

        // Register values outside the legal range are clamped.
        wait_idle();
        write_cfg(8'd255, 8'd0);
        add_frame(grid_w() * grid_h());
        wait_idle();
        write_cfg(8'd0, 8'hFF);
        add_frame(grid_w() * grid_h());
        wait_idle();
        write_cfg(8'd128, 8'd64);
        add_frame(300);
        wait_idle();
        write_cfg(8'd2, 8'd2);
        add_frame(grid_w() * grid_h());

        while (sent_items < ITEM_TARGET)
        begin
            random_phase();
        end

        wait_idle();
        if (fail_count == 0 && next_gen_q.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* life_cellular_automaton_step_top.f */
rtl/lcas_pkg.sv
rtl/lcas_cell.sv
rtl/lcas_window.sv
rtl/life_cellular_automaton_step_top.sv
verif/tb_life_cellular_automaton_step_top.sv
